@@ rtl/pwcr_pkg.sv @@
`default_nettype none

package pwcr_pkg;

   // Frame and counter sizing
   localparam int CODE_BITS   = 4;
   localparam int COUNT_WIDTH = 8;
   localparam int CFG_WIDTH   = 8;
   localparam int POS_WIDTH   = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;
   localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
   localparam int IDX_WIDTH   = 3;

   // Register indexes
   localparam logic [IDX_WIDTH-1:0] REG_START_MIN = 3'd0;
   localparam logic [IDX_WIDTH-1:0] REG_START_MAX = 3'd1;
   localparam logic [IDX_WIDTH-1:0] REG_ZERO_MIN  = 3'd2;
   localparam logic [IDX_WIDTH-1:0] REG_ZERO_MAX  = 3'd3;
   localparam logic [IDX_WIDTH-1:0] REG_ONE_MIN   = 3'd4;
   localparam logic [IDX_WIDTH-1:0] REG_ONE_MAX   = 3'd5;

   // Register reset values
   localparam logic [CFG_WIDTH-1:0] RST_START_MIN = 8'd9;
   localparam logic [CFG_WIDTH-1:0] RST_START_MAX = 8'd11;
   localparam logic [CFG_WIDTH-1:0] RST_ZERO_MIN  = 8'd2;
   localparam logic [CFG_WIDTH-1:0] RST_ZERO_MAX  = 8'd4;
   localparam logic [CFG_WIDTH-1:0] RST_ONE_MIN   = 8'd6;
   localparam logic [CFG_WIDTH-1:0] RST_ONE_MAX   = 8'd8;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] start_min;
      logic [CFG_WIDTH-1:0] start_max;
      logic [CFG_WIDTH-1:0] zero_min;
      logic [CFG_WIDTH-1:0] zero_max;
      logic [CFG_WIDTH-1:0] one_min;
      logic [CFG_WIDTH-1:0] one_max;
   } win_cfg_type;

   typedef struct packed {
      logic [CODE_BITS-1:0] code;
      logic                 code_done;
   } result_type;

   // Inclusive window test; an empty window (min above max) matches nothing.
   function automatic logic in_window(input logic [COUNT_WIDTH-1:0] w,
                                      input logic [CFG_WIDTH-1:0]   lo,
                                      input logic [CFG_WIDTH-1:0]   hi);
      logic [CMP_WIDTH-1:0] wx;
      logic [CMP_WIDTH-1:0] lox;
      logic [CMP_WIDTH-1:0] hix;
      wx  = CMP_WIDTH'(w);
      lox = CMP_WIDTH'(lo);
      hix = CMP_WIDTH'(hi);
      return (wx >= lox) && (wx <= hix);
   endfunction

endpackage

`default_nettype wire

@@ rtl/pulse_width_code_receiver_unit.sv @@
// Pulse-width code receiver: one line sample per transfer, one result per sample.
// Result: registered in the out register, or held in the skid while the out register is stalled.
// Throughput: one sample per cycle while rsp_stall is low. Under rsp_stall one more
//   sample lands in the skid, then req_stall holds until the skid drains.
// Reset: synchronous, active high; tracker idle, frame disarmed, code zero,
//   windows back to their defaults, output stage empty.
`default_nettype none

module pulse_width_code_receiver_unit
   import pwcr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // sample channel
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_line_level,
   // result channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [CODE_BITS-1:0]      rsp_code,
   output logic                      rsp_code_done,
   // window registers
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [IDX_WIDTH-1:0] csr_index,
   input  wire logic [CFG_WIDTH-1:0] csr_data
);

   win_cfg_type cfg_ff;
   result_type  result;

   // Output stage: out register facing rsp_*, skid behind it.
   logic       out_valid_ff;
   result_type out_data_ff;
   logic       skid_valid_ff;
   result_type skid_data_ff;

   logic req_xfer;
   logic out_free;

   // Register writes are always taken; unused indexes drop out.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_min <= RST_START_MIN;
         cfg_ff.start_max <= RST_START_MAX;
         cfg_ff.zero_min  <= RST_ZERO_MIN;
         cfg_ff.zero_max  <= RST_ZERO_MAX;
         cfg_ff.one_min   <= RST_ONE_MIN;
         cfg_ff.one_max   <= RST_ONE_MAX;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_START_MIN: cfg_ff.start_min <= csr_data;
            REG_START_MAX: cfg_ff.start_max <= csr_data;
            REG_ZERO_MIN:  cfg_ff.zero_min  <= csr_data;
            REG_ZERO_MAX:  cfg_ff.zero_max  <= csr_data;
            REG_ONE_MIN:   cfg_ff.one_min   <= csr_data;
            REG_ONE_MAX:   cfg_ff.one_max   <= csr_data;
            default: ;
         endcase
      end
   end

   // Stall only when the skid is occupied, so a waiting result never
   // blocks the next sample.
   assign req_stall = skid_valid_ff;
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;

   // Edge tracking, width capture and classification; state advances
   // once per sample transfer.
   pwcr_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .step       (req_xfer),
      .line_level (req_line_level),
      .cfg        (cfg_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            // skid drains first to keep order; no sample taken this cycle
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= req_xfer;
         end
      end else if (req_xfer) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
         end else if (req_xfer) begin
            out_data_ff <= result;
         end
      end else if (req_xfer) begin
         skid_data_ff <= result;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_code      = out_data_ff.code;
   assign rsp_code_done = out_data_ff.code_done;

endmodule

`default_nettype wire

@@ rtl/pwcr_tracker.sv @@
`default_nettype none

module pwcr_tracker
   import pwcr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire logic        line_level,
   input  wire win_cfg_type cfg,
   output result_type       result
);

   typedef enum logic [1:0] {
      WAIT_LOW,
      WAIT_HIGH,
      COUNTING
   } phase_type;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [POS_WIDTH-1:0]   POS_LAST  = POS_WIDTH'(CODE_BITS - 1);

   phase_type              phase_ff,    phase_in;
   logic [COUNT_WIDTH-1:0] ticks_ff,    ticks_in;
   logic                   pending_ff,  pending_in;
   logic [COUNT_WIDTH-1:0] width_ff,    width_in;
   logic                   armed_ff,    armed_in;
   logic [POS_WIDTH-1:0]   pos_ff,      pos_in;
   logic [CODE_BITS-1:0]   bits_ff,     bits_in;
   logic                   done;
   logic                   store;
   logic                   bit_val;
   logic [POS_WIDTH-1:0]   bit_idx;

   always_comb begin
      phase_in   = phase_ff;
      ticks_in   = ticks_ff;
      pending_in = pending_ff;
      width_in   = width_ff;
      armed_in   = armed_ff;
      pos_in     = pos_ff;
      bits_in    = bits_ff;
      done       = 1'b0;
      store      = 1'b0;
      bit_val    = 1'b0;
      bit_idx    = POS_LAST - pos_ff;

      if (pending_ff) begin
         // classify tick: line is ignored
         pending_in = 1'b0;
         if (!armed_ff) begin
            if (in_window(width_ff, cfg.start_min, cfg.start_max)) begin
               armed_in = 1'b1;
            end
         end else begin
            // zero window wins on overlap
            priority if (in_window(width_ff, cfg.zero_min, cfg.zero_max)) begin
               store   = 1'b1;
               bit_val = 1'b0;
            end else if (in_window(width_ff, cfg.one_min, cfg.one_max)) begin
               store   = 1'b1;
               bit_val = 1'b1;
            end else begin
               store   = 1'b0;
            end
            if (store) begin
               bits_in[bit_idx] = bit_val;
               if (pos_ff == POS_LAST) begin
                  pos_in   = '0;
                  armed_in = 1'b0;
                  done     = 1'b1;
               end else begin
                  pos_in = pos_ff + POS_WIDTH'(1);
               end
            end
         end
      end else begin
         unique case (phase_ff)
            WAIT_LOW: begin
               if (!line_level) phase_in = WAIT_HIGH;
            end
            WAIT_HIGH: begin
               if (line_level) phase_in = COUNTING;
            end
            COUNTING: begin
               if (line_level) begin
                  if (ticks_ff != COUNT_MAX) ticks_in = ticks_ff + COUNT_WIDTH'(1);
               end else begin
                  phase_in   = WAIT_LOW;
                  width_in   = ticks_ff;
                  ticks_in   = '0;
                  pending_in = 1'b1;
               end
            end
            default: begin
               phase_in = WAIT_LOW;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= WAIT_LOW;
         ticks_ff   <= '0;
         pending_ff <= 1'b0;
         width_ff   <= '0;
         armed_ff   <= 1'b0;
         pos_ff     <= '0;
         bits_ff    <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         ticks_ff   <= ticks_in;
         pending_ff <= pending_in;
         width_ff   <= width_in;
         armed_ff   <= armed_in;
         pos_ff     <= pos_in;
         bits_ff    <= bits_in;
      end
   end

   assign result.code      = bits_in;
   assign result.code_done = done;

endmodule

`default_nettype wire

@@ rtl/pwcr_checker.sv @@
`default_nettype none

module pwcr_checker
   import pwcr_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_stall,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire logic [CODE_BITS-1:0] rsp_code,
   input wire logic                 rsp_code_done
);

   logic rsp_xfer;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   // output stage comes out of reset empty and open
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("output stage not empty after reset");

   // input only backs up once a result is already waiting
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("stall raised with no result held");

   // after every sample transfer rsp_valid is high next cycle (it may still be an older held result)
   a_sample_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("sample transfer without result");

   // a frame end needs a falling edge before it, so back-to-back done is impossible
   a_done_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && rsp_code_done |=> !(rsp_xfer && rsp_code_done))
      else $error("two consecutive frame-done results");

   // held result stays put
   a_hold_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code) && $stable(rsp_code_done))
      else $error("stalled result changed");

endmodule

bind pulse_width_code_receiver_unit pwcr_checker u_pwcr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_code      (rsp_code),
   .rsp_code_done (rsp_code_done)
);

`default_nettype wire
